### design/pcrx_pkg.sv
// Shared types and constants for the SHA-1 PCR bank.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package pcrx_pkg;

	// Field widths
	localparam int IDX_W       = 5;
	localparam int WORD_W      = 32;
	localparam int PCR_W       = 160;
	localparam int ACT_W       = 2;
	localparam int IN_TDATA_W  = 168;  // 165 bits of fields, padded to bytes
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 160;
	localparam int OUT_TUSER_W = 1;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_EXTEND = 2'd2;

	// Status codes
	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_BAD = 1'b1;

	// SHA-1
	localparam int ROUNDS     = 80;
	localparam int ROUND_CNT_W = 7;
	localparam int SCHED_N    = 16;

	localparam logic [WORD_W-1:0] IV0 = 32'h6745_2301;
	localparam logic [WORD_W-1:0] IV1 = 32'hEFCD_AB89;
	localparam logic [WORD_W-1:0] IV2 = 32'h98BA_DCFE;
	localparam logic [WORD_W-1:0] IV3 = 32'h1032_5476;
	localparam logic [WORD_W-1:0] IV4 = 32'hC3D2_E1F0;

	localparam logic [WORD_W-1:0] K0 = 32'h5A82_7999;
	localparam logic [WORD_W-1:0] K1 = 32'h6ED9_EBA1;
	localparam logic [WORD_W-1:0] K2 = 32'h8F1B_BCDC;
	localparam logic [WORD_W-1:0] K3 = 32'hCA62_C1D6;

	// Padding words for a 40-byte message in one block
	localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LEN_WORD = 32'd320;

	// Round function groups
	localparam logic [1:0] GRP_CH  = 2'd0;
	localparam logic [1:0] GRP_P1  = 2'd1;
	localparam logic [1:0] GRP_MAJ = 2'd2;
	localparam logic [1:0] GRP_P2  = 2'd3;

	typedef logic [WORD_W-1:0] word_t;

	// Controller -> datapath
	typedef struct packed {
		logic       capture;    // input transfer this cycle
		logic       load_hash;  // seed state and schedule
		logic       round;      // run one compression round
		logic [1:0] grp;        // round function group
		logic       finish;     // write back and load output register
	} dp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             bad_idx;
		logic             out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

### design/pcrx_ctrl.sv
// Sequencer for the PCR bank: input handshake, round counter, write-back.
// Depends on pcrx_pkg.
`default_nettype none

module pcrx_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire pcrx_pkg::dp_stat_t stat,
	output pcrx_pkg::dp_cmd_t      cmd
);
	import pcrx_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOAD  = 2'd1;
	localparam logic [1:0] ST_ROUND = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]             state_q;
	logic [ROUND_CNT_W-1:0] cnt_q;
	logic                   last_round;
	logic                   do_extend;

	assign s_tready   = (state_q == ST_IDLE);
	assign last_round = (cnt_q == ROUND_CNT_W'(ROUNDS - 1));
	assign do_extend  = !stat.bad_idx && (stat.action == ACT_EXTEND);

	always_comb begin
		cmd           = '0;
		cmd.capture   = s_tvalid && s_tready;
		cmd.load_hash = (state_q == ST_LOAD) && do_extend;
		cmd.round     = (state_q == ST_ROUND);
		cmd.finish    = (state_q == ST_FIN) && stat.out_free;
		priority if (cnt_q < ROUND_CNT_W'(20))
			cmd.grp = GRP_CH;
		else if (cnt_q < ROUND_CNT_W'(40))
			cmd.grp = GRP_P1;
		else if (cnt_q < ROUND_CNT_W'(60))
			cmd.grp = GRP_MAJ;
		else
			cmd.grp = GRP_P2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= do_extend ? ST_ROUND : ST_FIN;
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + ROUND_CNT_W'(1);
					if (last_round)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (stat.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/pcrx_dp.sv
// Datapath: register memory with row valid bits, SHA-1 round unit with
// 16-word schedule window, input latch and output register. Uses pcrx_pkg.
`default_nettype none

module pcrx_dp #(
	parameter int NUM_PCRS = 24
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [pcrx_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  wire logic [pcrx_pkg::IN_TUSER_W-1:0]   s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [pcrx_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic [pcrx_pkg::OUT_TUSER_W-1:0]       m_tuser,
	input  wire pcrx_pkg::dp_cmd_t                 cmd,
	output pcrx_pkg::dp_stat_t                     stat
);
	import pcrx_pkg::*;

	localparam int AW = (NUM_PCRS > 1) ? $clog2(NUM_PCRS) : 1;

	// register storage
	logic [PCR_W-1:0]    mem [NUM_PCRS];
	logic [NUM_PCRS-1:0] valid_q;
	logic [PCR_W-1:0]    rd_q;
	logic                rdv_q;

	// latched item
	logic [ACT_W-1:0] act_q;
	logic             bad_q;
	logic [AW-1:0]    addr_q;
	logic [PCR_W-1:0] val_q;

	// hash state
	word_t a_q, b_q, c_q, d_q, e_q;
	word_t w_q [SCHED_N];

	// output register
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tuser_q;

	logic [IDX_W-1:0] in_idx;
	logic             in_bad;
	logic [AW-1:0]    in_addr;
	logic [PCR_W-1:0] in_val;
	logic [PCR_W-1:0] old_val;
	logic [PCR_W-1:0] digest;
	logic [PCR_W-1:0] res;
	logic             wr_en;
	word_t            f, k, t, w_new;

	assign in_idx  = s_tdata[IDX_W-1:0];
	assign in_bad  = {1'b0, in_idx} >= (IDX_W + 1)'(NUM_PCRS);
	assign in_addr = in_idx[AW-1:0];
	// top, middle, bottom
	assign in_val  = {s_tdata[36:5], s_tdata[100:37], s_tdata[164:101]};
	assign old_val = rdv_q ? rd_q : '0;

	// round logic
	always_comb begin
		unique case (cmd.grp)
			GRP_CH:  begin f = (b_q & c_q) | (~b_q & d_q);              k = K0; end
			GRP_P1:  begin f = b_q ^ c_q ^ d_q;                         k = K1; end
			GRP_MAJ: begin f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2; end
			default: begin f = b_q ^ c_q ^ d_q;                         k = K3; end
		endcase
	end

	assign t     = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
	assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};

	assign digest = {IV0 + a_q, IV1 + b_q, IV2 + c_q, IV3 + d_q, IV4 + e_q};

	assign wr_en = cmd.finish && !bad_q && (act_q == ACT_WRITE || act_q == ACT_EXTEND);

	always_comb begin
		res = '0;
		if (!bad_q) begin
			if (act_q == ACT_READ)
				res = old_val;
			else if (act_q == ACT_EXTEND)
				res = digest;
		end
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr_q] <= (act_q == ACT_WRITE) ? val_q : digest;
		if (cmd.capture && !in_bad)
			rd_q <= mem[in_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rdv_q      <= 1'b0;
			act_q      <= ACT_READ;
			bad_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[addr_q] <= 1'b1;
			if (cmd.capture) begin
				rdv_q <= !in_bad && valid_q[in_addr];
				act_q <= s_tuser;
				bad_q <= in_bad;
			end
			if (cmd.finish)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= in_addr;
			val_q  <= in_val;
		end
		if (cmd.load_hash) begin
			a_q <= IV0;
			b_q <= IV1;
			c_q <= IV2;
			d_q <= IV3;
			e_q <= IV4;
			for (int i = 0; i < 5; i++) begin
				w_q[i]     <= old_val[PCR_W-1-WORD_W*i -: WORD_W];
				w_q[5 + i] <= val_q[PCR_W-1-WORD_W*i -: WORD_W];
			end
			w_q[10] <= PAD_WORD;
			w_q[11] <= '0;
			w_q[12] <= '0;
			w_q[13] <= '0;
			w_q[14] <= '0;
			w_q[15] <= LEN_WORD;
		end else if (cmd.round) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < SCHED_N - 1; i++)
				w_q[i] <= w_q[i + 1];
			w_q[SCHED_N-1] <= w_new;
		end
		if (cmd.finish) begin
			m_tdata_q <= {res[63:0], res[127:64], res[159:128]};
			m_tuser_q <= bad_q ? STAT_BAD : STAT_OK;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign stat.action   = act_q;
	assign stat.bad_idx  = bad_q;
	assign stat.out_free = !m_tvalid_q || m_tready;

endmodule

`default_nettype wire

### design/pcr_bank_sha1_extend.sv
// Top level of the SHA-1 PCR bank: sequencer plus datapath.
// Depends on pcrx_pkg, pcrx_ctrl and pcrx_dp.
//
//  channel  | dir | tdata (low bit up)                        | tuser
//  ---------+-----+-------------------------------------------+---------------
//  s_*      | in  | pcr_index, value_top, value_middle,       | action
//           |     | value_bottom, 3 zero pad bits             |
//  m_*      | out | result_top, result_middle, result_bottom  | status
//
// Steps: an extend result is valid after memory read, state load, 80 rounds of
// the single SHA-1 round unit and write-back; read, write and bad index skip
// the rounds. s_tready comes back in the same cycle as the result becomes valid,
// so the input stays busy for the whole of each item.
// Reset: arst_n clears the row valid bits, so every register reads as zero
// until written; no clearing pass is needed.
// Stalls: the result sits in an output register; s_tready returns once the
// result is loaded, even while m_tready is low. A new result waits in the
// write-back step until the output register is free.
`default_nettype none

module pcr_bank_sha1_extend #(
	parameter int NUM_PCRS = 24
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// pcr_index[4:0], value_top[36:5], value_middle[100:37],
	// value_bottom[164:101], zero pad[167:165]
	input  wire logic [pcrx_pkg::IN_TDATA_W-1:0]  s_tdata,
	// action[1:0]
	input  wire logic [pcrx_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// result_top[31:0], result_middle[95:32], result_bottom[159:96]
	output logic [pcrx_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// status[0]
	output logic [pcrx_pkg::OUT_TUSER_W-1:0]      m_tuser
);
	import pcrx_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: handshake, round count, write-back timing
	pcrx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, hash rounds and output register
	pcrx_dp #(
		.NUM_PCRS (NUM_PCRS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

`default_nettype wire

### design/pcrx_chk.sv
// Port-level checker for the SHA-1 PCR bank, bound to the top level.
// Depends on pcrx_pkg.
`default_nettype none

module pcrx_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [pcrx_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic [pcrx_pkg::OUT_TUSER_W-1:0] m_tuser
);
	import pcrx_pkg::*;

	// one item at a time: no transfer right after a transfer
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// bad index gives all-zero data
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_BAD) |-> (m_tdata == '0))
		else $error("bad-index result carries data");

	// a result never appears in the cycle after an input transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result before the item was processed");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind pcr_bank_sha1_extend pcrx_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
